// File: rtl/gsuf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsuf_pkg
// Shared types and constants of the graph segmentation union-find block.
// ----------------------------------------------------------------------------
package gsuf_pkg;

  // operation codes of an input transfer
  typedef enum logic [1:0] {
    OP_INIT    = 2'd0,
    OP_THRESH  = 2'd1,
    OP_MINSIZE = 2'd2,
    OP_QUERY   = 2'd3
  } opcode_t;

  // control sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_RD,
    S_CHK,
    S_PTR,
    S_DECIDE,
    S_WGONE,
    S_DIV,
    S_WKEEP,
    S_RESULT
  } state_t;

  // configuration register indexes
  localparam logic [1:0] REG_SCALE      = 2'd0;
  localparam logic [1:0] REG_SIZE_FLOOR = 2'd1;
  localparam logic [1:0] REG_VCOUNT     = 2'd2;

  localparam int RANK_W = 5;
  localparam int SIZE_W = 17;
  localparam int DIV_W  = 32;

  localparam logic [RANK_W-1:0] RANK_MAX = 5'd31;
  localparam logic [SIZE_W-1:0] SIZE_MAX = 17'h1FFFF;

  localparam logic [31:0] SCALE_RESET = 32'd32768000;
  localparam logic [16:0] SIZE_FLOOR_RESET = 17'd20;
  localparam logic [16:0] VCOUNT_RESET = 17'd65536;

endpackage : gsuf_pkg
`default_nettype wire

// File: rtl/gsuf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsuf_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module gsuf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule : gsuf_ram
`default_nettype wire

// File: rtl/graph_segment_union_find_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// graph_segment_union_find_top
// Disjoint-set forest for graph segmentation, one entry per vertex in RAM.
// ----------------------------------------------------------------------------
// Every vertex owns one RAM word holding parent, rank, size and threshold;
// all work is a read-modify-write sequence on that single RAM (one read, one
// write per cycle, registered read data). No clearing pass follows reset:
// an init transfer writes vertices 0 to count-1, one per cycle. A query walks
// the parent links of its vertex; an edge walks both endpoints and, when the
// two sets are joined, writes both roots. A threshold merge that joins also
// runs a bit-serial division of the scale constant by the new set size.
// Edges must arrive sorted by weight. Out-of-range transfers go straight to
// the result with status set. A finished result sits in the output register
// so the next transfer can be taken meanwhile.
module graph_segment_union_find_top #(
  parameter int MAX_VERTICES = 65536,
  parameter int WEIGHT_BITS  = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [15:0] vertex_a,
  input  wire logic [15:0] vertex_b,
  input  wire logic [31:0] weight,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      root_label,
  output logic             joined,
  output logic [16:0]      component_size,
  output logic [16:0]      set_count,
  output logic             status,
  // configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  import gsuf_pkg::*;

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int WB = WEIGHT_BITS;
  localparam int EW = IW + RANK_W + SIZE_W + WB;
  localparam int SW = ((WB > 32) ? WB : 32) + 1;
  localparam logic [SW-1:0] WMAX = SW'({WB{1'b1}});

  // configuration
  logic [31:0] scale_c;
  logic [16:0] size_floor;
  logic [16:0] vcount;

  // control and datapath registers
  state_t state, state_next;
  opcode_t op;
  logic phase_b;
  logic [IW-1:0] va_r, vb_r, cur, walk_cnt;
  logic [WB-1:0] w_r;
  logic first;
  logic [RANK_W-1:0] st_rank;
  logic [SIZE_W-1:0] st_size;
  logic [WB-1:0] st_thr;
  logic [IW-1:0] a_id, a_par, b_id, b_par;
  logic [RANK_W-1:0] a_rank, b_rank;
  logic [SIZE_W-1:0] a_size, b_size;
  logic [WB-1:0] a_thr, b_thr;
  logic [IW-1:0] keep_id, keep_par, gone_id;
  logic [RANK_W-1:0] gone_rank, n_rank;
  logic [SIZE_W-1:0] gone_size, n_size;
  logic [WB-1:0] keep_thr, gone_thr;
  logic [16:0] init_idx;
  logic [16:0] sets_left;
  logic [SIZE_W-1:0] div_d, div_rem;
  logic [DIV_W-1:0] div_quo;
  logic [4:0] div_cnt;
  logic [IW-1:0] res_label;
  logic [SIZE_W-1:0] res_size;
  logic res_joined, res_status;

  // ram port
  logic ram_we;
  logic [IW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  gsuf_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_VERTICES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(cur),
    .rdata(ram_rdata)
  );

  // fields of the word read back
  logic [IW-1:0] rd_par;
  logic [RANK_W-1:0] rd_rank;
  logic [SIZE_W-1:0] rd_size;
  logic [WB-1:0] rd_thr;
  assign rd_par  = ram_rdata[EW-1 -: IW];
  assign rd_rank = ram_rdata[WB+SIZE_W +: RANK_W];
  assign rd_size = ram_rdata[WB +: SIZE_W];
  assign rd_thr  = ram_rdata[WB-1:0];

  // vertices in use and range checks
  logic [16:0] cnt;
  logic va_ok, vb_ok;
  opcode_t in_op;
  assign cnt = (32'(vcount) > MAX_VERTICES - 1) ? 17'(MAX_VERTICES) : vcount;
  assign in_op = opcode_t'(opcode);
  assign va_ok = {1'b0, vertex_a} < cnt;
  assign vb_ok = {1'b0, vertex_b} < cnt;

  // initial threshold, clipped to the largest weight
  logic [WB-1:0] t0;
  assign t0 = (SW'(scale_c) > WMAX) ? WB'(WMAX) : WB'(SW'(scale_c));

  // end of a parent walk
  logic walk_done;
  assign walk_done = (rd_par == cur) || (32'(rd_par) >= MAX_VERTICES) ||
                     (walk_cnt == IW'(MAX_VERTICES - 1));

  // merge decision
  logic thr_ok, min_ok, do_merge, a_gt;
  logic [SIZE_W:0] size_sum;
  assign thr_ok = (op == OP_THRESH) && (w_r <= a_thr) && (w_r <= b_thr);
  assign min_ok = (op == OP_MINSIZE) && ((a_size < size_floor) || (b_size < size_floor));
  assign do_merge = (a_id != b_id) && (thr_ok || min_ok);
  assign a_gt = a_rank > b_rank;
  assign size_sum = {1'b0, a_size} + {1'b0, b_size};

  // divider step and new threshold
  logic [SIZE_W:0] div_trial;
  logic div_ge;
  logic [SW-1:0] thr_sum;
  logic [WB-1:0] thr_new;
  assign div_trial = {div_rem, div_quo[DIV_W-1]};
  assign div_ge = div_trial >= {1'b0, div_d};
  assign thr_sum = SW'(w_r) + SW'(div_quo);
  assign thr_new = (op != OP_THRESH) ? keep_thr :
                   (thr_sum > WMAX) ? WB'(WMAX) : WB'(thr_sum);

  logic out_free;
  assign out_free = !out_valid || out_ready;
  assign cfg_ready = !rst;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_INIT) begin
            state_next = (cnt != 17'd0) ? S_INIT : S_RESULT;
          end else if (!va_ok || (in_op != OP_QUERY && !vb_ok)) begin
            state_next = S_RESULT;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_INIT:   if (init_idx == cnt - 17'd1) state_next = S_RESULT;
      S_RD:     state_next = S_CHK;
      S_CHK:    state_next = walk_done ? S_PTR : S_RD;
      S_PTR: begin
        if (op == OP_QUERY) state_next = S_RESULT;
        else if (!phase_b) state_next = S_RD;
        else state_next = S_DECIDE;
      end
      S_DECIDE: state_next = do_merge ? S_WGONE : S_RESULT;
      S_WGONE:  state_next = (op == OP_THRESH) ? S_DIV : S_WKEEP;
      S_DIV:    if (div_cnt == 5'd31) state_next = S_WKEEP;
      S_WKEEP:  state_next = S_RESULT;
      S_RESULT: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // ram writes and input handshake
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur;
    ram_wdata = '0;
    in_ready  = (state == S_IDLE) && !rst;
    unique case (state)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = IW'(init_idx);
        ram_wdata = {IW'(init_idx), {RANK_W{1'b0}}, SIZE_W'(1), t0};
      end
      S_PTR: begin
        ram_we    = 1'b1;
        ram_waddr = phase_b ? vb_r : va_r;
        ram_wdata = {(phase_b ? b_id : a_id), st_rank, st_size, st_thr};
      end
      S_WGONE: begin
        ram_we    = 1'b1;
        ram_waddr = gone_id;
        ram_wdata = {keep_id, gone_rank, gone_size, gone_thr};
      end
      S_WKEEP: begin
        ram_we    = 1'b1;
        ram_waddr = keep_id;
        ram_wdata = {keep_par, n_rank, n_size, thr_new};
      end
      default: ram_we = 1'b0;
    endcase
  end

  // state register and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      sets_left  <= '0;
      out_valid  <= 1'b0;
      scale_c    <= SCALE_RESET;
      size_floor <= SIZE_FLOOR_RESET;
      vcount     <= VCOUNT_RESET;
    end else begin
      state <= state_next;
      // configuration writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_SCALE:      scale_c    <= cfg_data;
          REG_SIZE_FLOOR: size_floor <= cfg_data[16:0];
          REG_VCOUNT:     vcount     <= cfg_data[16:0];
          default:        ;
        endcase
      end
      if (state == S_IDLE && in_valid && in_op == OP_INIT) begin
        sets_left <= cnt;
      end
      if (state == S_WKEEP && sets_left != 17'd0) begin
        sets_left <= sets_left - 17'd1;
      end
      // result register
      if (state == S_RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        op         <= in_op;
        va_r       <= IW'(vertex_a);
        vb_r       <= IW'(vertex_b);
        w_r        <= WB'(weight);
        cur        <= IW'(vertex_a);
        first      <= 1'b1;
        walk_cnt   <= '0;
        phase_b    <= 1'b0;
        init_idx   <= '0;
        res_label  <= '0;
        res_size   <= '0;
        res_joined <= 1'b0;
        res_status <= (in_op != OP_INIT) &&
                      (!va_ok || (in_op != OP_QUERY && !vb_ok));
      end
      S_INIT: init_idx <= init_idx + 17'd1;
      S_CHK: begin
        walk_cnt <= walk_cnt + IW'(1);
        first    <= 1'b0;
        if (first) begin
          st_rank <= rd_rank;
          st_size <= rd_size;
          st_thr  <= rd_thr;
        end
        if (!walk_done) begin
          cur <= rd_par;
        end else if (!phase_b) begin
          a_id <= cur; a_par <= rd_par; a_rank <= rd_rank;
          a_size <= rd_size; a_thr <= rd_thr;
        end else begin
          b_id <= cur; b_par <= rd_par; b_rank <= rd_rank;
          b_size <= rd_size; b_thr <= rd_thr;
        end
      end
      S_PTR: begin
        res_label <= a_id;
        res_size  <= a_size;
        phase_b   <= 1'b1;
        cur       <= vb_r;
        first     <= 1'b1;
        walk_cnt  <= '0;
      end
      S_DECIDE: begin
        keep_id   <= a_gt ? a_id : b_id;
        keep_par  <= a_gt ? a_par : b_par;
        keep_thr  <= a_gt ? a_thr : b_thr;
        gone_id   <= a_gt ? b_id : a_id;
        gone_rank <= a_gt ? b_rank : a_rank;
        gone_size <= a_gt ? b_size : a_size;
        gone_thr  <= a_gt ? b_thr : a_thr;
        if (a_gt) n_rank <= a_rank;
        else if (a_rank == b_rank && b_rank < RANK_MAX) n_rank <= b_rank + RANK_W'(1);
        else n_rank <= b_rank;
        n_size <= size_sum[SIZE_W] ? SIZE_MAX : size_sum[SIZE_W-1:0];
      end
      S_WGONE: begin
        div_d   <= (n_size == '0) ? SIZE_W'(1) : n_size;
        div_rem <= '0;
        div_quo <= scale_c;
        div_cnt <= '0;
      end
      S_DIV: begin
        // one quotient bit per cycle, restoring
        div_rem <= div_ge ? SIZE_W'(div_trial - {1'b0, div_d}) : SIZE_W'(div_trial);
        div_quo <= {div_quo[DIV_W-2:0], div_ge};
        div_cnt <= div_cnt + 5'd1;
      end
      S_WKEEP: begin
        res_label  <= keep_id;
        res_size   <= n_size;
        res_joined <= 1'b1;
      end
      S_RESULT: begin
        if (out_free) begin
          root_label     <= 16'(res_label);
          joined         <= res_joined;
          component_size <= res_size;
          set_count      <= sets_left;
          status         <= res_status;
        end
      end
      default: ;
    endcase
  end

  // checks
  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> !joined && component_size == '0 && root_label == '0)
    else $error("ignored transfer carries a result");

  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    state == S_CHK |-> $past(state) == S_RD)
    else $error("walk checked data without a read");

  a_sets_down: assert property (@(posedge clk) disable iff (rst)
    state == S_WKEEP |=> sets_left <= $past(sets_left))
    else $error("set count rose on a merge");

  a_merge_ok: assert property (@(posedge clk) disable iff (rst)
    state == S_WGONE |-> $past(state) == S_DECIDE && a_id != b_id)
    else $error("merge of a set with itself");

endmodule : graph_segment_union_find_top
`default_nettype wire

// File: sim/graph_segment_union_find_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_segment_union_find_top_tb
// Self-checking bench for the union-find segmentation block: a shadow forest
// predicts every result, transfers are driven and checked under random stalls.
// ----------------------------------------------------------------------------
module graph_segment_union_find_top_tb;
  import gsuf_pkg::*;

  localparam int NV         = 65536;
  localparam int IDLE_PCT   = 33;
  localparam int WDOG_LIMIT = 300000;

  typedef struct {
    opcode_t     op;
    logic [15:0] va;
    logic [15:0] vb;
    logic [31:0] w;
  } edge_item_t;

  typedef struct {
    logic [15:0] label;
    logic        joined;
    logic [16:0] csize;
    logic [16:0] sets;
    logic        status;
  } seg_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode = '0;
  logic [15:0] vertex_a = '0;
  logic [15:0] vertex_b = '0;
  logic [31:0] weight = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] root_label;
  logic        joined;
  logic [16:0] component_size;
  logic [16:0] set_count;
  logic        status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  graph_segment_union_find_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
    .vertex_a(vertex_a), .vertex_b(vertex_b), .weight(weight),
    .out_valid(out_valid), .out_ready(out_ready), .root_label(root_label),
    .joined(joined), .component_size(component_size), .set_count(set_count),
    .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow forest and registers
  logic [15:0] sh_parent [NV];
  logic [4:0]  sh_rank   [NV];
  logic [16:0] sh_size   [NV];
  logic [31:0] sh_thr    [NV];
  logic [16:0] sh_sets = '0;
  logic [31:0] sh_scale = SCALE_RESET;
  logic [16:0] sh_size_floor = SIZE_FLOOR_RESET;
  logic [16:0] sh_vcount = VCOUNT_RESET;

  edge_item_t  pending_items[$];
  seg_result_t expected_results[$];
  int          fails = 0;
  bit          calm = 1'b0;
  int          hold_go = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  function automatic int live_count();
    return (sh_vcount > NV) ? NV : int'(sh_vcount);
  endfunction

  function automatic int walk_root(int v);
    int r;
    r = v;
    for (int n = 0; n < NV; n++) begin
      if (int'(sh_parent[r]) == r) break;
      r = sh_parent[r];
    end
    return r;
  endfunction

  function automatic int point_at_root(int v);
    int r;
    r = walk_root(v);
    sh_parent[v] = r[15:0];
    return r;
  endfunction

  function automatic int join_roots(int x, int y);
    int keep, gone;
    logic [17:0] s;
    if (sh_rank[x] > sh_rank[y]) begin
      keep = x; gone = y;
    end else begin
      keep = y; gone = x;
      if (sh_rank[x] == sh_rank[y] && sh_rank[y] < RANK_MAX) sh_rank[y] = sh_rank[y] + 5'd1;
    end
    sh_parent[gone] = keep[15:0];
    s = {1'b0, sh_size[keep]} + {1'b0, sh_size[gone]};
    sh_size[keep] = (s > {1'b0, SIZE_MAX}) ? SIZE_MAX : s[16:0];
    if (sh_sets > 17'd0) sh_sets = sh_sets - 17'd1;
    return keep;
  endfunction

  // one step of the shadow forest
  function automatic seg_result_t segment_step(edge_item_t it);
    seg_result_t res;
    int cnt, a, b, r, lbl;
    logic [16:0] d;
    logic [32:0] t;
    cnt = live_count();
    res = '{label: '0, joined: 1'b0, csize: '0, sets: '0, status: 1'b0};
    if (it.op == OP_INIT) begin
      for (int i = 0; i < cnt; i++) begin
        sh_parent[i] = i[15:0];
        sh_rank[i] = '0;
        sh_size[i] = 17'd1;
        sh_thr[i] = sh_scale;
      end
      sh_sets = cnt[16:0];
    end else if (int'(it.va) >= cnt || (it.op != OP_QUERY && int'(it.vb) >= cnt)) begin
      res.status = 1'b1;
    end else begin
      if (it.op == OP_QUERY) begin
        a = point_at_root(it.va);
      end else begin
        a = point_at_root(it.va);
        b = point_at_root(it.vb);
        if (a != b) begin
          if (it.op == OP_THRESH) begin
            if (it.w <= sh_thr[a] && it.w <= sh_thr[b]) begin
              r = join_roots(a, b);
              d = (sh_size[r] == 0) ? 17'd1 : sh_size[r];
              t = {1'b0, it.w} + {1'b0, sh_scale / {15'd0, d}};
              sh_thr[r] = t[32] ? 32'hFFFF_FFFF : t[31:0];
              res.joined = 1'b1;
            end
          end else if (sh_size[a] < sh_size_floor || sh_size[b] < sh_size_floor) begin
            r = join_roots(a, b);
            res.joined = 1'b1;
          end
        end
      end
      lbl = walk_root(it.va);
      res.label = lbl[15:0];
      res.csize = sh_size[lbl];
    end
    res.sets = sh_sets;
    return res;
  endfunction

  // input driver
  always @(posedge clk) begin
    edge_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_items.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        it = pending_items.pop_front();
        in_valid <= 1'b1;
        opcode   <= it.op;
        vertex_a <= it.va;
        vertex_b <= it.vb;
        weight   <= it.w;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver, with a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // prediction on input transfer, checking on result transfer
  always @(posedge clk) begin
    edge_item_t  it;
    seg_result_t exp_r;
    if (!rst) begin
      if (in_valid && in_ready) begin
        it = '{op: opcode_t'(opcode), va: vertex_a, vb: vertex_b, w: weight};
        expected_results.push_back(segment_step(it));
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected");
          fails++;
        end else begin
          exp_r = expected_results.pop_front();
          if (root_label !== exp_r.label) begin
            $error("root_label expected %0d actual %0d", exp_r.label, root_label);
            fails++;
          end
          if (joined !== exp_r.joined) begin
            $error("joined expected %0d actual %0d", exp_r.joined, joined);
            fails++;
          end
          if (component_size !== exp_r.csize) begin
            $error("component_size expected %0d actual %0d", exp_r.csize, component_size);
            fails++;
          end
          if (set_count !== exp_r.sets) begin
            $error("set_count expected %0d actual %0d", exp_r.sets, set_count);
            fails++;
          end
          if (status !== exp_r.status) begin
            $error("status expected %0d actual %0d", exp_r.status, status);
            fails++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    int quiet;
    if (rst) begin
      quiet = 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready) ||
                 (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic add_item(opcode_t op, int va, int vb, logic [31:0] w);
    pending_items.push_back('{op: op, va: va[15:0], vb: vb[15:0], w: w});
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // register write while the block is idle
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    wait_drained();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SCALE:      sh_scale = val;
      REG_SIZE_FLOOR: sh_size_floor = val[16:0];
      REG_VCOUNT:     sh_vcount = val[16:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // one random phase: init, then mostly sorted edges with random endpoints
  task automatic run_phase(int n_items, int vcnt, logic [31:0] scale, int floor_sz);
    logic [32:0] wacc;
    logic [31:0] step_max;
    int pick, cnt;
    write_reg(REG_VCOUNT, vcnt);
    write_reg(REG_SCALE, scale);
    write_reg(REG_SIZE_FLOOR, floor_sz);
    cnt = vcnt;
    step_max = (scale >> 5) + 32'd1;
    wacc = $urandom_range(0, 3) == 0 ? {1'b0, 32'hFFFF_FFF0} : {1'b0, $urandom() % step_max};
    add_item(OP_INIT, $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom());
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        wacc = wacc + ($urandom() % step_max);
        if (wacc[32]) wacc = {1'b0, 32'hFFFF_FFFF};
        add_item(OP_THRESH, $urandom_range(0, cnt - 1), $urandom_range(0, cnt - 1), wacc[31:0]);
      end else if (pick < 70) begin
        add_item(OP_MINSIZE, $urandom_range(0, cnt - 1), $urandom_range(0, cnt - 1), $urandom());
      end else if (pick < 88) begin
        add_item(OP_QUERY, $urandom_range(0, cnt - 1), $urandom(), $urandom());
      end else if (pick < 90) begin
        add_item(OP_INIT, $urandom(), $urandom(), $urandom());
      end else begin
        // out-of-range second endpoint, sometimes the first as well
        add_item(opcode_t'($urandom_range(1, 3)),
                 $urandom_range(0, 1) ? $urandom_range(cnt, 65535) : $urandom_range(0, cnt - 1),
                 $urandom_range(cnt, 65535), $urandom());
      end
    end
  endtask

  // stimulus sequence
  initial begin
    logic [31:0] sc;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: full vertex range with reset registers
    add_item(OP_INIT, 65535, 65535, 32'hFFFF_FFFF);
    add_item(OP_THRESH, 0, 1, 32'd0);
    add_item(OP_THRESH, 65535, 65534, 32'd100 << 16);
    add_item(OP_MINSIZE, 2, 3, 32'd0);
    add_item(OP_MINSIZE, 65535, 0, 32'hFFFF_FFFF);
    add_item(OP_QUERY, 65535, 0, 32'd0);
    add_item(OP_QUERY, 1, 65535, 32'hFFFF_FFFF);
    add_item(OP_THRESH, 1, 65535, 32'hFFFF_FFFF);
    add_item(OP_THRESH, 0, 0, 32'hFFFF_FFFF);
    add_item(OP_MINSIZE, 3, 2, 32'd0);
    add_item(OP_QUERY, 65534, 0, 32'd0);
    // directed: no vertex in range
    write_reg(REG_VCOUNT, 0);
    add_item(OP_INIT, 0, 0, 32'd0);
    add_item(OP_QUERY, 0, 0, 32'd0);
    add_item(OP_THRESH, 0, 0, 32'd0);
    add_item(OP_MINSIZE, 0, 65535, 32'd0);
    // directed: saturating thresholds and a single vertex
    write_reg(REG_SCALE, 32'hFFFF_FFFF);
    write_reg(REG_SIZE_FLOOR, 65536);
    write_reg(REG_VCOUNT, 1);
    add_item(OP_INIT, 0, 0, 32'd0);
    add_item(OP_QUERY, 0, 0, 32'd0);
    add_item(OP_THRESH, 0, 1, 32'd0);
    add_item(OP_MINSIZE, 0, 0, 32'd0);
    write_reg(REG_VCOUNT, 4);
    add_item(OP_INIT, 0, 0, 32'd0);
    add_item(OP_THRESH, 0, 1, 32'hFFFF_FFFE);
    add_item(OP_THRESH, 2, 3, 32'hFFFF_FFFF);
    add_item(OP_THRESH, 1, 3, 32'hFFFF_FFFF);

    // random phases
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: sc = SCALE_RESET;
        1: sc = 32'd0;
        2: sc = 32'hFFFF_FFFF;
        default: sc = $urandom();
      endcase
      calm = (ph == 3);
      run_phase(150, $urandom_range(2, 48), sc,
                (ph == 5) ? 0 : (ph == 6) ? 65536 : $urandom_range(1, 12));
      // long receiver hold-off while items keep coming
      if (ph == 2) hold_go++;
    end

    wait_drained();
    repeat (50) @(negedge clk);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/gsuf_pkg.sv
rtl/gsuf_ram.sv
rtl/graph_segment_union_find_top.sv
sim/graph_segment_union_find_top_tb.sv
